// ----- rtl/qts_pkg.sv -----
// shared types and character constants for the quoted token splitter
`default_nettype none

package qts_pkg;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_END   = 2'd1,
    KIND_OK    = 2'd2,
    KIND_UNBAL = 2'd3
  } kind_e;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_NEWLINE = 8'h0a;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_SQUOTE  = 8'h27;
  localparam logic [7:0] CH_BSLASH  = 8'h5c;
  localparam logic [7:0] CH_BQUOTE  = 8'h60;
  localparam logic [7:0] CH_LOWER_N = 8'h6e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data_byte;
    logic [7:0] token_count;
    logic       last;
  } result_t;

  typedef struct packed {
    logic       in_single_quote;
    logic       in_double_quote;
    logic       inside_token;
    logic       escape_pending;
    logic [7:0] tokens_done;
  } state_t;

  // up to two results caused by one item, in order
  typedef struct packed {
    result_t    r0;
    result_t    r1;
    logic [1:0] num;
  } pair_t;

endpackage

`default_nettype wire

// ----- rtl/qts_if.sv -----
// valid/ready channel interfaces for the input bytes and the results
`default_nettype none

interface qts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink (input valid, input ch, output ready);
endinterface

interface qts_out_if;
  logic              valid;
  logic              ready;
  qts_pkg::kind_e    kind;
  logic [7:0]        data_byte;
  logic [7:0]        token_count;
  logic              last;

  modport source (output valid, output kind, output data_byte, output token_count,
                  output last, input ready);
  modport sink (input valid, input kind, input data_byte, input token_count,
                input last, output ready);
endinterface

`default_nettype wire

// ----- rtl/qts_decode.sv -----
// per-byte next-state and result logic of the token splitter
`default_nettype none

module qts_decode #(
  parameter int unsigned MaxTokens = 128
) (
  input  qts_pkg::state_t state_i,
  input  logic [7:0]      ch_i,
  output qts_pkg::state_t state_o,
  output qts_pkg::pair_t  pair_o
);

  function automatic qts_pkg::result_t mk_res(qts_pkg::kind_e k, logic [7:0] b,
                                              logic [7:0] c);
    qts_pkg::result_t r;
    r.kind        = k;
    r.data_byte   = b;
    r.token_count = c;
    r.last        = 1'b0;
    return r;
  endfunction

  logic       handled;
  logic       first_used;
  logic [1:0] num;
  qts_pkg::state_t  st;
  qts_pkg::result_t r0;
  qts_pkg::result_t r1;
  qts_pkg::result_t esc_res;
  logic             esc_put;
  logic             dq_special;

  assign dq_special = (ch_i == qts_pkg::CH_DQUOTE) || (ch_i == qts_pkg::CH_BSLASH) ||
                      (ch_i == qts_pkg::CH_DOLLAR) || (ch_i == qts_pkg::CH_BQUOTE) ||
                      (ch_i == qts_pkg::CH_NEWLINE);

  always_comb begin
    st         = state_i;
    handled    = 1'b0;
    esc_put    = 1'b0;
    esc_res    = mk_res(qts_pkg::KIND_BYTE, ch_i, state_i.tokens_done);
    first_used = 1'b0;
    num        = 2'd0;
    r0         = mk_res(qts_pkg::KIND_OK, qts_pkg::CH_NUL, state_i.tokens_done);
    r1         = r0;

    // escape resolution, at most one result
    if (state_i.escape_pending) begin
      st.escape_pending = 1'b0;
      if (state_i.in_double_quote) begin
        esc_put = 1'b1;
        if (dq_special) begin
          handled = 1'b1;
        end else if (ch_i == qts_pkg::CH_LOWER_N) begin
          esc_res.data_byte = qts_pkg::CH_NEWLINE;
          handled = 1'b1;
        end else begin
          esc_res.data_byte = qts_pkg::CH_BSLASH;
        end
      end else if (ch_i != qts_pkg::CH_NUL) begin
        esc_put = 1'b1;
        handled = 1'b1;
      end
    end

    if (esc_put) begin
      r0         = esc_res;
      first_used = 1'b1;
      num        = 2'd1;
    end

    if (!handled) begin
      if (ch_i == qts_pkg::CH_NUL) begin
        if (st.in_single_quote || st.in_double_quote) begin
          if (first_used) begin
            r1 = mk_res(qts_pkg::KIND_UNBAL, qts_pkg::CH_NUL, st.tokens_done);
          end else begin
            r0 = mk_res(qts_pkg::KIND_UNBAL, qts_pkg::CH_NUL, st.tokens_done);
          end
          num = num + 2'd1;
        end else begin
          // escape before end of line outside quotes emits nothing, so r0 is free here
          if (st.inside_token) begin
            if (st.tokens_done < 8'(MaxTokens)) begin
              st.tokens_done = st.tokens_done + 8'd1;
            end
            r0  = mk_res(qts_pkg::KIND_END, qts_pkg::CH_NUL, st.tokens_done);
            r1  = mk_res(qts_pkg::KIND_OK, qts_pkg::CH_NUL, st.tokens_done);
            num = 2'd2;
          end else begin
            r0  = mk_res(qts_pkg::KIND_OK, qts_pkg::CH_NUL, st.tokens_done);
            num = 2'd1;
          end
        end
        st = '0;
      end else if (ch_i == qts_pkg::CH_SQUOTE && !st.in_double_quote) begin
        st.in_single_quote = ~st.in_single_quote;
      end else if (ch_i == qts_pkg::CH_DQUOTE && !st.in_single_quote) begin
        st.in_double_quote = ~st.in_double_quote;
      end else if (ch_i == qts_pkg::CH_SPACE && !st.in_double_quote &&
                   !st.in_single_quote) begin
        if (st.inside_token) begin
          if (st.tokens_done < 8'(MaxTokens)) begin
            st.tokens_done = st.tokens_done + 8'd1;
          end
          r0              = mk_res(qts_pkg::KIND_END, qts_pkg::CH_NUL, st.tokens_done);
          num             = 2'd1;
          st.inside_token = 1'b0;
        end
      end else if (ch_i == qts_pkg::CH_BSLASH && !st.in_single_quote) begin
        st.escape_pending = 1'b1;
        st.inside_token   = 1'b1;
      end else begin
        if (first_used) begin
          r1 = mk_res(qts_pkg::KIND_BYTE, ch_i, st.tokens_done);
        end else begin
          r0 = mk_res(qts_pkg::KIND_BYTE, ch_i, st.tokens_done);
        end
        num             = num + 2'd1;
        st.inside_token = 1'b1;
      end
    end

    if (num == 2'd1) begin
      r0.last = 1'b1;
    end
    if (num == 2'd2) begin
      r1.last = 1'b1;
    end
  end

  assign state_o     = st;
  assign pair_o.r0   = r0;
  assign pair_o.r1   = r1;
  assign pair_o.num  = num;

endmodule

`default_nettype wire

// ----- rtl/qts_outbuf.sv -----
// two-slot result register that drains the results of one item in order
`default_nettype none

module qts_outbuf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  qts_pkg::pair_t    pair_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output qts_pkg::result_t  out_res_o,
  output logic              in_ready_o
);

  logic [1:0]       cnt_q, cnt_d;
  qts_pkg::result_t slot0_q, slot0_d;
  qts_pkg::result_t slot1_q;
  logic             take;

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_res_o   = slot0_q;
  assign take        = out_valid_o && out_ready_i;
  // free when empty or when the only waiting item leaves this cycle
  assign in_ready_o  = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ready_i);

  always_comb begin
    cnt_d   = cnt_q;
    slot0_d = slot0_q;
    if (load_i) begin
      cnt_d   = pair_i.num;
      slot0_d = pair_i.r0;
    end else if (take) begin
      cnt_d   = cnt_q - 2'd1;
      slot0_d = slot1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    if (load_i) begin
      slot1_q <= pair_i.r1;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("result count out of range");

  a_load_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> (cnt_q == 2'd0) || (cnt_q == 2'd1 && take))
    else $error("new item loaded over waiting results");

  a_pair_head_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |-> !slot0_q.last)
    else $error("first of two results flagged last");

endmodule

`default_nettype wire

// ----- rtl/quoted_token_splitter_core.sv -----
// top level of the quoted token splitter: flag state, decode and result buffer
// output: the first result of an item is offered the cycle after the item is accepted,
//   a second result of the same item the cycle after the first is taken
// throughput: one item per cycle while each item causes at most one result and the output is
//   ready; an item with two results holds the single result port, and so the input, until both are taken
// reset: asynchronous, clears quote, token and escape flags, the token count and the buffer
`default_nettype none

module quoted_token_splitter_core #(
  parameter int unsigned MaxTokens = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  qts_in_if.sink            in_i,
  qts_out_if.source         out_o
);

  qts_pkg::state_t  state_q, state_d;
  qts_pkg::pair_t   pair;
  qts_pkg::result_t out_res;
  logic             accept;
  logic             in_ready;

  assign accept     = in_i.valid && in_ready;
  assign in_i.ready = in_ready;

  qts_decode #(
    .MaxTokens (MaxTokens)
  ) u_decode (
    .state_i (state_q),
    .ch_i    (in_i.ch),
    .state_o (state_d),
    .pair_o  (pair)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  qts_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .pair_i      (pair),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_res_o   (out_res),
    .in_ready_o  (in_ready)
  );

  assign out_o.kind        = out_res.kind;
  assign out_o.data_byte   = out_res.data_byte;
  assign out_o.token_count = out_res.token_count;
  assign out_o.last        = out_res.last;

  a_line_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.ch == qts_pkg::CH_NUL) |=> (state_q == '0))
    else $error("state not cleared after end of line");

  a_line_result_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.kind == qts_pkg::KIND_OK || out_o.kind == qts_pkg::KIND_UNBAL))
    |-> out_o.last)
    else $error("line result not last of its item");

  a_non_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.kind != qts_pkg::KIND_BYTE) |-> (out_o.data_byte == 8'd0))
    else $error("data byte set on a non-byte result");

  a_count_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.tokens_done <= 8'(MaxTokens))
    else $error("token count beyond saturation");

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// testbench for quoted_token_splitter_core: byte stream in, token results checked
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import qts_pkg::*;

  localparam int unsigned TOKEN_LIMIT  = 128;
  localparam int unsigned RANDOM_ITEMS = 1500;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DIR_ROWS     = 27;

  typedef struct packed {
    logic [7:0] ch;
    logic       typed;
    result_t    res;
  } stim_row_t;

  logic clk;
  logic rst_ni;

  qts_in_if  byte_ch ();
  qts_out_if result_ch ();

  quoted_token_splitter_core #(
    .MaxTokens(TOKEN_LIMIT)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_ni),
    .in_i  (byte_ch),
    .out_o (result_ch)
  );

  // splitter state as seen from the accepted bytes
  logic       quote_single;
  logic       quote_double;
  logic       token_open;
  logic       escape_armed;
  logic [7:0] token_tally;

  result_t     pending_results[$];
  logic [7:0]  line_q[$];
  stim_row_t   dir_table[DIR_ROWS];
  int unsigned error_count;
  int unsigned cycles;
  int unsigned random_sent;
  int unsigned line_idx;
  bit          idle_on;

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic void append_result(inout pair_t p, input kind_e k, input logic [7:0] d);
    result_t r;
    r.kind = k;
    r.data_byte = d;
    r.token_count = token_tally;
    r.last = 1'b0;
    if (p.num == 2'd0) p.r0 = r;
    else p.r1 = r;
    p.num = p.num + 2'd1;
  endfunction

  function automatic void close_token();
    if (token_tally < 8'(TOKEN_LIMIT)) token_tally = token_tally + 8'd1;
  endfunction

  // results caused by one byte, updating the tracked state
  function automatic pair_t split_byte(input logic [7:0] b);
    pair_t p;
    logic  done;
    p = '0;
    done = 1'b0;
    if (escape_armed) begin
      escape_armed = 1'b0;
      if (quote_double) begin
        if (b == CH_DQUOTE || b == CH_BSLASH || b == CH_DOLLAR || b == CH_BQUOTE ||
            b == CH_NEWLINE) begin
          append_result(p, KIND_BYTE, b);
          done = 1'b1;
        end else if (b == CH_LOWER_N) begin
          append_result(p, KIND_BYTE, CH_NEWLINE);
          done = 1'b1;
        end else begin
          // backslash stays literal, byte falls through
          append_result(p, KIND_BYTE, CH_BSLASH);
        end
      end else if (b != CH_NUL) begin
        append_result(p, KIND_BYTE, b);
        done = 1'b1;
      end
    end
    if (!done) begin
      if (b == CH_NUL) begin
        if (quote_single || quote_double) begin
          append_result(p, KIND_UNBAL, 8'h00);
        end else begin
          if (token_open) begin
            close_token();
            append_result(p, KIND_END, 8'h00);
          end
          append_result(p, KIND_OK, 8'h00);
        end
        quote_single = 1'b0;
        quote_double = 1'b0;
        token_open = 1'b0;
        escape_armed = 1'b0;
        token_tally = 8'd0;
      end else if (b == CH_SQUOTE && !quote_double) begin
        quote_single = ~quote_single;
      end else if (b == CH_DQUOTE && !quote_single) begin
        quote_double = ~quote_double;
      end else if (b == CH_SPACE && !quote_double && !quote_single) begin
        if (token_open) begin
          close_token();
          append_result(p, KIND_END, 8'h00);
          token_open = 1'b0;
        end
      end else if (b == CH_BSLASH && !quote_single) begin
        escape_armed = 1'b1;
        token_open = 1'b1;
      end else begin
        append_result(p, KIND_BYTE, b);
        token_open = 1'b1;
      end
    end
    if (p.num == 2'd2) p.r1.last = 1'b1;
    else if (p.num == 2'd1) p.r0.last = 1'b1;
    return p;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic use_typed, input result_t typed_res);
    pair_t p;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      byte_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    byte_ch.valid <= 1'b1;
    byte_ch.ch <= b;
    do @(posedge clk); while (!byte_ch.ready);
    p = split_byte(b);
    if (use_typed) begin
      pending_results.push_back(typed_res);
    end else begin
      if (p.num > 2'd0) pending_results.push_back(p.r0);
      if (p.num > 2'd1) pending_results.push_back(p.r1);
    end
  endtask

  task automatic wait_drain();
    byte_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  function automatic logic [7:0] plain_char();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255));
    while (b == CH_SPACE || b == CH_SQUOTE || b == CH_DQUOTE || b == CH_BSLASH);
    return b;
  endfunction

  function automatic logic [7:0] dq_escape_char();
    case ($urandom_range(0, 6))
      0: return CH_DQUOTE;
      1: return CH_BSLASH;
      2: return CH_DOLLAR;
      3: return CH_BQUOTE;
      4: return CH_NEWLINE;
      5: return CH_LOWER_N;
      default: return plain_char();
    endcase
  endfunction

  function automatic void add_word();
    logic [7:0] b;
    int unsigned pieces;
    pieces = $urandom_range(1, 3);
    for (int unsigned i = 0; i < pieces; i++) begin
      case ($urandom_range(0, 4))
        0, 1: begin
          repeat ($urandom_range(1, 4)) line_q.push_back(plain_char());
        end
        2: begin
          line_q.push_back(CH_SQUOTE);
          repeat ($urandom_range(0, 4)) begin
            do b = 8'($urandom_range(1, 255)); while (b == CH_SQUOTE);
            line_q.push_back(b);
          end
          line_q.push_back(CH_SQUOTE);
        end
        3: begin
          line_q.push_back(CH_DQUOTE);
          repeat ($urandom_range(0, 4)) begin
            if ($urandom_range(0, 2) == 0) begin
              line_q.push_back(CH_BSLASH);
              line_q.push_back(dq_escape_char());
            end else begin
              do b = 8'($urandom_range(1, 255)); while (b == CH_DQUOTE || b == CH_BSLASH);
              line_q.push_back(b);
            end
          end
          line_q.push_back(CH_DQUOTE);
        end
        default: begin
          line_q.push_back(CH_BSLASH);
          line_q.push_back(8'($urandom_range(1, 255)));
        end
      endcase
    end
  endfunction

  // one line ending in NUL: mostly well-formed words, sometimes long or noisy
  function automatic void build_line(input bit force_long);
    int unsigned pick;
    int unsigned words;
    line_q.delete();
    pick = $urandom_range(0, 99);
    if (force_long || pick < 3) begin
      // enough tokens to hit the count saturation
      words = $urandom_range(130, 200);
      repeat (words) begin
        line_q.push_back(plain_char());
        line_q.push_back(CH_SPACE);
      end
    end else if (pick < 85) begin
      if ($urandom_range(0, 3) == 0) line_q.push_back(CH_SPACE);
      words = $urandom_range(0, 8);
      for (int unsigned w = 0; w < words; w++) begin
        add_word();
        if (w + 1 < words || $urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 2)) line_q.push_back(CH_SPACE);
      end
      if ($urandom_range(0, 19) == 0) line_q.push_back(CH_BSLASH);
    end else begin
      repeat ($urandom_range(1, 16)) begin
        case ($urandom_range(0, 7))
          0: line_q.push_back(CH_SQUOTE);
          1: line_q.push_back(CH_DQUOTE);
          2: line_q.push_back(CH_BSLASH);
          3: line_q.push_back(CH_SPACE);
          default: line_q.push_back(8'($urandom_range(0, 255)));
        endcase
      end
    end
    line_q.push_back(CH_NUL);
  endfunction

  // result side: random stall bursts while idling is on
  initial begin
    result_ch.ready = 1'b1;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        result_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    result_t seen;
    result_t want;
    if (rst_ni && result_ch.valid && result_ch.ready) begin
      seen = '{result_ch.kind, result_ch.data_byte, result_ch.token_count, result_ch.last};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result kind %0d byte %h count %0d last %0d", $time,
                 seen.kind, seen.data_byte, seen.token_count, seen.last);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (seen !== want) begin
          $display("%0t: expected kind %0d byte %h count %0d last %0d, got kind %0d byte %h count %0d last %0d",
                   $time, want.kind, want.data_byte, want.token_count, want.last,
                   seen.kind, seen.data_byte, seen.token_count, seen.last);
          error_count++;
        end
      end
    end
  end

  initial begin
    clk = 1'b0;
    rst_ni = 1'b0;
    byte_ch.valid = 1'b0;
    byte_ch.ch = CH_NUL;
    quote_single = 1'b0;
    quote_double = 1'b0;
    token_open = 1'b0;
    escape_armed = 1'b0;
    token_tally = 8'd0;
    error_count = 0;
    cycles = 0;
    random_sent = 0;
    idle_on = 1'b1;

    dir_table = '{
      '{CH_NUL,    1'b1, '{KIND_OK,    8'h00, 8'd0, 1'b1}},  // empty line
      '{8'h61,     1'b1, '{KIND_BYTE,  8'h61, 8'd0, 1'b1}},
      '{8'hff,     1'b1, '{KIND_BYTE,  8'hff, 8'd0, 1'b1}},
      '{CH_SPACE,  1'b1, '{KIND_END,   8'h00, 8'd1, 1'b1}},
      '{CH_SPACE,  1'b0, '0},                                 // space outside a token
      '{CH_SQUOTE, 1'b0, '0},
      '{CH_DQUOTE, 1'b0, '0},                                 // literal in single quotes
      '{CH_BSLASH, 1'b0, '0},
      '{CH_SQUOTE, 1'b0, '0},
      '{CH_DQUOTE, 1'b0, '0},
      '{CH_BSLASH, 1'b0, '0},
      '{CH_LOWER_N, 1'b0, '0},                                // becomes newline
      '{CH_BSLASH, 1'b0, '0},
      '{8'h01,     1'b0, '0},                                 // literal backslash plus byte
      '{CH_BSLASH, 1'b0, '0},
      '{CH_BQUOTE, 1'b0, '0},
      '{CH_DQUOTE, 1'b0, '0},
      '{CH_BSLASH, 1'b0, '0},
      '{CH_NUL,    1'b0, '0},                                 // trailing backslash, token end then ok
      '{CH_SQUOTE, 1'b0, '0},
      '{CH_SQUOTE, 1'b0, '0},
      '{CH_NUL,    1'b1, '{KIND_OK,    8'h00, 8'd0, 1'b1}},  // empty quotes open nothing
      '{CH_DQUOTE, 1'b0, '0},
      '{CH_BSLASH, 1'b0, '0},
      '{CH_NUL,    1'b0, '0},                                 // backslash then unbalanced
      '{CH_SQUOTE, 1'b0, '0},
      '{CH_NUL,    1'b1, '{KIND_UNBAL, 8'h00, 8'd0, 1'b1}}
    };

    repeat (2) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    foreach (dir_table[i]) send_byte(dir_table[i].ch, dir_table[i].typed, dir_table[i].res);

    line_idx = 0;
    while (random_sent < RANDOM_ITEMS) begin
      build_line(line_idx == 0);
      foreach (line_q[i]) begin
        send_byte(line_q[i], 1'b0, '0);
        random_sent++;
      end
      line_idx++;
      if (line_idx == 6) wait_drain();
      if (random_sent + 200 > RANDOM_ITEMS) idle_on = 1'b0;
    end

    wait_drain();
    repeat (16) @(posedge clk);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
